// File: hdl/i2cm_pkg.sv
package i2cm_pkg;

  localparam int DIVIDER_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF   = 16;

  localparam logic [15:0] TICKS_RESET   = 16'd80;
  localparam logic [7:0]  ADDR_DIR_MASK = 8'hfe;
  localparam logic [7:0]  ADDR_READ_BIT = 8'h01;

  // Request codes carried on the action field.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Completion status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ADDR_NAK = 2'd1;
  localparam logic [1:0] ST_DATA_NAK = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_BIT_LOW  = 4'd2,
    PH_BIT_HIGH = 4'd3,
    PH_ACK_LOW  = 4'd4,
    PH_ACK_HIGH = 4'd5,
    PH_STOP_A   = 4'd6,
    PH_STOP_B   = 4'd7,
    PH_STOP_C   = 4'd8
  } phase_t;

endpackage

// File: hdl/i2cm_in_if.sv
interface i2cm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  address_byte;
  logic [15:0] byte_count;
  logic [7:0]  tx_byte;
  logic        sda_in;

  modport source (output valid, action, address_byte, byte_count, tx_byte, sda_in,
                  input ready);
  modport sink (input valid, action, address_byte, byte_count, tx_byte, sda_in,
                output ready);
endinterface

// File: hdl/i2cm_out_if.sv
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       byte_taken;
  logic [7:0] rx_byte;
  logic       rx_valid;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, scl_out, sda_out, busy_res, byte_taken, rx_byte,
                  rx_valid, done_res, status, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, byte_taken, rx_byte,
                rx_valid, done_res, status, output ready);
endinterface

// File: hdl/i2cm_cfg_if.sv
interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hdl/i2cm_phase_timer.sv
module i2cm_phase_timer #(
  parameter int DIVIDER_WIDTH = i2cm_pkg::DIVIDER_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic [DIVIDER_WIDTH-1:0] limit,
  output logic                     phase_end
);
  import i2cm_pkg::*;

  logic [DIVIDER_WIDTH-1:0] cnt_r;
  logic [DIVIDER_WIDTH-1:0] cnt_nxt;
  logic [DIVIDER_WIDTH-1:0] cnt_inc;
  logic [DIVIDER_WIDTH-1:0] eff_limit;

  // A limit of zero behaves as one tick per phase.
  assign eff_limit = (limit == '0) ? DIVIDER_WIDTH'(1) : limit;
  assign cnt_inc   = cnt_r + DIVIDER_WIDTH'(1);
  assign phase_end = (cnt_inc >= eff_limit);

  always_comb begin
    cnt_nxt = cnt_r;
    if (step) begin
      cnt_nxt = phase_end ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/i2c_master_byte_transfer.sv
// Channel   Direction  Handshake            Carries
// in_if     sink       valid/ready          action, address_byte, byte_count, tx_byte, sda_in
// out_if    source     valid/ready          scl_out, sda_out, busy_res, byte_taken, rx_byte,
//                                           rx_valid, done_res, status
// cfg_if    sink       valid/ready          ticks_per_phase write data
//
// One request is accepted per clock unless the output register stalls, and its result appears
// in the output register on the next cycle; the bus state update itself is a single pass through the phase logic.
// The output register decouples the sides: a request is taken whenever the register is
// empty or is being drained in the same cycle, so a stalled result stops input only then.
// Synchronous active-low reset returns the bus to idle with SCL and SDA released and the
// phase divider at 80 ticks. cfg_if is always ready; the user must write it only while idle, as the block has no check.
module i2c_master_byte_transfer #(
  parameter int DIVIDER_WIDTH = i2cm_pkg::DIVIDER_WIDTH_DEF,
  parameter int COUNT_WIDTH   = i2cm_pkg::COUNT_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  i2cm_in_if.sink   in_if,
  i2cm_out_if.source out_if,
  i2cm_cfg_if.sink  cfg_if
);
  import i2cm_pkg::*;

  logic [15:0] ticks_r;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             bit_r, bit_nxt;
  logic [COUNT_WIDTH-1:0] left_r, left_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   is_read_r, is_read_nxt;
  logic                   addr_stage_r, addr_stage_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic [1:0]             code_r, code_nxt;

  logic       out_valid_r;
  logic       o_scl_r, o_sda_r, o_busy_r, o_taken_r, o_rxv_r, o_done_r;
  logic [7:0] o_rxb_r;
  logic [1:0] o_stat_r;

  logic       taken, rxv, done;
  logic [7:0] rxb;
  logic [1:0] stat;
  logic [7:0] sampled;
  logic       receiving;
  logic       accept;
  logic       phase_end;
  logic [COUNT_WIDTH-1:0]   count_in;
  logic [DIVIDER_WIDTH-1:0] limit;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;
  assign accept       = in_if.valid && in_if.ready;
  assign receiving    = is_read_r && !addr_stage_r;
  assign count_in     = COUNT_WIDTH'(in_if.byte_count);
  assign limit        = DIVIDER_WIDTH'(ticks_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      ticks_r <= cfg_if.data;
    end
  end

  i2cm_phase_timer #(
    .DIVIDER_WIDTH(DIVIDER_WIDTH)
  ) u_timer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept && (phase_r != PH_IDLE)),
    .limit     (limit),
    .phase_end (phase_end)
  );

  always_comb begin
    phase_nxt      = phase_r;
    bit_nxt        = bit_r;
    left_nxt       = left_r;
    shift_nxt      = shift_r;
    is_read_nxt    = is_read_r;
    addr_stage_nxt = addr_stage_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    code_nxt       = code_r;
    taken          = 1'b0;
    rxv            = 1'b0;
    rxb            = 8'd0;
    done           = 1'b0;
    stat           = ST_OK;
    sampled        = shift_r;
    if (receiving && in_if.sda_in) begin
      sampled[bit_r] = 1'b1;
    end

    if (phase_r == PH_IDLE) begin
      if (in_if.action == ACT_WRITE || in_if.action == ACT_READ) begin
        is_read_nxt    = (in_if.action == ACT_READ);
        shift_nxt      = (in_if.action == ACT_READ) ? (in_if.address_byte | ADDR_READ_BIT)
                                                    : (in_if.address_byte & ADDR_DIR_MASK);
        left_nxt       = count_in;
        // A read of zero bytes still moves one byte.
        if (in_if.action == ACT_READ && count_in == '0) begin
          left_nxt = COUNT_WIDTH'(1);
        end
        code_nxt       = ST_OK;
        addr_stage_nxt = 1'b1;
        bit_nxt        = 3'd0;
        phase_nxt      = PH_START;
        scl_nxt        = 1'b1;
        sda_nxt        = 1'b0;
      end
    end else if (phase_end) begin
      unique case (phase_r)
        PH_START: begin
          bit_nxt   = 3'd7;
          phase_nxt = PH_BIT_LOW;
          scl_nxt   = 1'b0;
          sda_nxt   = shift_r[7];
        end
        PH_BIT_LOW: begin
          phase_nxt = PH_BIT_HIGH;
          scl_nxt   = 1'b1;
        end
        PH_BIT_HIGH: begin
          shift_nxt = sampled;
          scl_nxt   = 1'b0;
          if (bit_r != 3'd0) begin
            bit_nxt   = bit_r - 3'd1;
            phase_nxt = PH_BIT_LOW;
            sda_nxt   = receiving ? 1'b1 : shift_r[bit_r - 3'd1];
          end else begin
            phase_nxt = PH_ACK_LOW;
            // The master acknowledges every read byte except the last.
            sda_nxt   = receiving ? !(left_r > COUNT_WIDTH'(1)) : 1'b1;
          end
        end
        PH_ACK_LOW: begin
          phase_nxt = PH_ACK_HIGH;
          scl_nxt   = 1'b1;
        end
        PH_ACK_HIGH: begin
          scl_nxt = 1'b0;
          if (receiving) begin
            rxv = 1'b1;
            rxb = shift_r;
            if (left_r > COUNT_WIDTH'(1)) begin
              left_nxt  = left_r - COUNT_WIDTH'(1);
              shift_nxt = 8'd0;
              bit_nxt   = 3'd7;
              phase_nxt = PH_BIT_LOW;
              sda_nxt   = 1'b1;
            end else begin
              left_nxt  = '0;
              phase_nxt = PH_STOP_A;
              sda_nxt   = 1'b0;
            end
          end else if (in_if.sda_in) begin
            code_nxt  = addr_stage_r ? ST_ADDR_NAK : ST_DATA_NAK;
            phase_nxt = PH_STOP_A;
            sda_nxt   = 1'b0;
          end else begin
            addr_stage_nxt = 1'b0;
            if (is_read_r) begin
              shift_nxt = 8'd0;
              bit_nxt   = 3'd7;
              phase_nxt = PH_BIT_LOW;
              sda_nxt   = 1'b1;
            end else if (left_r == '0) begin
              phase_nxt = PH_STOP_A;
              sda_nxt   = 1'b0;
            end else begin
              left_nxt  = left_r - COUNT_WIDTH'(1);
              taken     = 1'b1;
              shift_nxt = in_if.tx_byte;
              bit_nxt   = 3'd7;
              phase_nxt = PH_BIT_LOW;
              sda_nxt   = in_if.tx_byte[7];
            end
          end
        end
        PH_STOP_A: begin
          phase_nxt = PH_STOP_B;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b0;
        end
        PH_STOP_B: begin
          phase_nxt = PH_STOP_C;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
        end
        default: begin
          phase_nxt      = PH_IDLE;
          scl_nxt        = 1'b1;
          sda_nxt        = 1'b1;
          addr_stage_nxt = 1'b0;
          done           = 1'b1;
          stat           = code_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_r        <= 3'd0;
      left_r       <= '0;
      shift_r      <= 8'd0;
      is_read_r    <= 1'b0;
      addr_stage_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      code_r       <= ST_OK;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      bit_r        <= bit_nxt;
      left_r       <= left_nxt;
      shift_r      <= shift_nxt;
      is_read_r    <= is_read_nxt;
      addr_stage_r <= addr_stage_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      code_r       <= code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_scl_r   <= scl_nxt;
      o_sda_r   <= sda_nxt;
      o_busy_r  <= (phase_nxt != PH_IDLE);
      o_taken_r <= taken;
      o_rxb_r   <= rxb;
      o_rxv_r   <= rxv;
      o_done_r  <= done;
      o_stat_r  <= stat;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.scl_out    = o_scl_r;
  assign out_if.sda_out    = o_sda_r;
  assign out_if.busy_res   = o_busy_r;
  assign out_if.byte_taken = o_taken_r;
  assign out_if.rx_byte    = o_rxb_r;
  assign out_if.rx_valid   = o_rxv_r;
  assign out_if.done_res   = o_done_r;
  assign out_if.status     = o_stat_r;

  // When the bus is idle both lines are released.
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> scl_r && sda_r)
    else $error("bus idle with a line pulled low");

  // A completed STOP always leaves the master idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done |=> phase_r == PH_IDLE && !out_if.busy_res)
    else $error("STOP completed but master still busy");

  // A write byte is only fetched during a write transfer, a read byte only during a read.
  a_taken_write: assert property (@(posedge clk) disable iff (!rst_n)
    accept && taken |-> !is_read_r && !rxv)
    else $error("tx byte taken during a read");

  a_rx_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept && rxv |-> is_read_r && !addr_stage_r)
    else $error("rx byte reported outside a read data phase");

  // Data bits change only while SCL is low, except for START and STOP conditions.
  a_sda_scl_low: assert property (@(posedge clk) disable iff (!rst_n)
    accept && scl_r && scl_nxt && (sda_nxt != sda_r) |->
      phase_nxt == PH_START || phase_nxt == PH_STOP_C)
    else $error("SDA changed while SCL high");

endmodule
